FILE: rtl/core/load_cell_moving_average_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the load-cell moving-average block.
// Each macro checks a property on the rising clock edge while out of reset.
// ---------------------------------------------------------------------------
`ifndef LOAD_CELL_MOVING_AVERAGE_ASSERT_SVH
`define LOAD_CELL_MOVING_AVERAGE_ASSERT_SVH

// The expression holds at every clock edge.
`define LCMA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("lcma: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define LCMA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcma: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define LCMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcma: next-cycle check failed");

`endif

FILE: rtl/core/lcma_pkg.sv
// ---------------------------------------------------------------------------
// lcma_pkg
// Shared types and constants of the load-cell moving-average block.
// ---------------------------------------------------------------------------
package lcma_pkg;

  localparam int unsigned SAMPLE_W      = 31;
  localparam int unsigned WEIGHT_W      = 30;
  localparam int unsigned WINDOW_W      = 5;
  localparam int unsigned KG_FRAC_BITS  = 16;
  localparam int unsigned GRAMS_PER_KG  = 1000;
  localparam int unsigned IN_DATA_W     = 32;
  localparam int unsigned OUT_DATA_W    = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } lcma_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } lcma_div_stat_t;

endpackage

FILE: rtl/core/lcma_ring.sv
// ---------------------------------------------------------------------------
// lcma_ring
// Sample ring memory with one shared address, registered read data and a
// valid bit per entry; an entry that was never written reads as zero.
// ---------------------------------------------------------------------------
module lcma_ring #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wr_data_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_q;
  logic [Depth-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[addr_i];
      if (clear_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/core/lcma_div.sv
// ---------------------------------------------------------------------------
// lcma_div
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lcma_div #(
  parameter int unsigned NumW = 43,
  parameter int unsigned DenW = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NumW-1:0]         num_i,
  input  logic [DenW-1:0]         den_i,
  output logic [NumW-1:0]         quot_o,
  output lcma_pkg::lcma_div_stat_t stat_o
);

  import lcma_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] numq_q, numq_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   rem_shift;
  logic [DenW:0]   rem_sub;
  logic            ge;

  always_comb begin
    rem_shift = {rem_q, numq_q[NumW-1]};
    ge        = rem_shift >= {1'b0, den_q};
    rem_sub   = rem_shift - {1'b0, den_q};
    numq_d    = numq_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      numq_d = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      numq_d = {numq_q[NumW-2:0], ge};
      rem_d  = ge ? rem_sub[DenW-1:0] : rem_shift[DenW-1:0];
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    numq_q <= numq_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quot_o      = numq_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/load_cell_moving_average.sv
// ---------------------------------------------------------------------------
// load_cell_moving_average
// A fresh sample beat passes the ring update, the bit-serial divider and
// the finish state before its result beat is valid; a held beat goes from
// idle straight to the finish state, which waits while the previous output
// beat is not yet taken. One beat is in work at a time. Reset clears the ring
// valid bits, position, count, sum and last weight and sets the window to 8;
// the block is ready after reset.
// ---------------------------------------------------------------------------
module load_cell_moving_average #(
  parameter int unsigned MAX_WINDOW       = 16,
  parameter int unsigned SAMPLE_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample_grams
  input  logic        s_axis_tuser_i,   // [0] sensor_ready
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [29:0] weight_kg, [34:30] samples_in_average
  output logic        m_axis_tuser_o,   // [0] held
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i        // [4:0] window_size
);

  import lcma_pkg::*;

  localparam int unsigned IdxW    = $clog2(MAX_WINDOW);
  localparam int unsigned SumW    = SAMPLE_W + IdxW;
  localparam int unsigned NumW    = SumW + KG_FRAC_BITS - SAMPLE_FRAC_BITS;
  localparam int unsigned DenW    = $clog2(GRAMS_PER_KG * MAX_WINDOW + 1);
  localparam int unsigned DefWin  = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

  lcma_state_e         state_q, state_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [WINDOW_W-1:0] fill_q, fill_d;
  logic [WINDOW_W-1:0] window_q, window_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [WEIGHT_W-1:0] last_weight_q, last_weight_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic [WEIGHT_W-1:0] res_weight_q, res_weight_d;
  logic                res_held_q, res_held_d;
  logic                m_valid_q, m_valid_d;
  logic [WEIGHT_W-1:0] m_weight_q;
  logic [WINDOW_W-1:0] m_fill_q;
  logic                m_held_q;
  logic                load_out;

  logic                s_fire;
  logic                cfg_fire;
  logic                ring_wr;
  logic [SAMPLE_W-1:0] ring_rd;
  logic                div_start;
  logic [NumW-1:0]     div_num;
  logic [DenW-1:0]     div_den;
  logic [NumW-1:0]     div_quot;
  lcma_div_stat_t      div_stat;
  logic [WEIGHT_W-1:0] quot_sat;
  logic [7:0]          pos_next;

  lcma_ring #(
    .Depth (MAX_WINDOW),
    .Width (SAMPLE_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_fire),
    .wr_en_i   (ring_wr),
    .addr_i    (pos_q),
    .wr_data_i (sample_q),
    .rd_data_o (ring_rd)
  );

  lcma_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  assign div_num  = NumW'(sum_q) << (KG_FRAC_BITS - SAMPLE_FRAC_BITS);
  assign div_den  = DenW'(fill_q) * DenW'(GRAMS_PER_KG);
  assign quot_sat = (div_quot[NumW-1:WEIGHT_W] != '0) ? '1 : div_quot[WEIGHT_W-1:0];
  assign pos_next = 8'(pos_q) + 8'd1;

  always_comb begin
    state_d         = state_q;
    pos_d           = pos_q;
    fill_d          = fill_q;
    window_d        = window_q;
    sum_d           = sum_q;
    last_weight_d   = last_weight_q;
    res_weight_d    = res_weight_q;
    res_held_d      = res_held_q;
    m_valid_d       = m_valid_q && !m_axis_tready_i;
    s_axis_tready_o = (state_q == ST_IDLE) && !cfg_valid_i;
    cfg_ready_o     = (state_q == ST_IDLE);
    s_fire          = s_axis_tvalid_i && s_axis_tready_o;
    cfg_fire        = cfg_valid_i && cfg_ready_o;
    ring_wr         = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          if (cfg_data_i == '0 || 32'(cfg_data_i) > MAX_WINDOW) begin
            window_d = WINDOW_W'(DefWin);
          end else begin
            window_d = cfg_data_i;
          end
          pos_d  = '0;
          fill_d = '0;
          sum_d  = '0;
        end else if (s_fire) begin
          if (s_axis_tuser_i) begin
            state_d = ST_UPDATE;
          end else begin
            res_weight_d = last_weight_q;
            res_held_d   = 1'b1;
            state_d      = ST_FINISH;
          end
        end
      end
      ST_UPDATE: begin
        ring_wr = 1'b1;
        sum_d   = sum_q - SumW'(ring_rd) + SumW'(sample_q);
        pos_d   = (pos_next >= 8'(window_q)) ? '0 : pos_next[IdxW-1:0];
        if (fill_q < window_q) begin
          fill_d = fill_q + WINDOW_W'(1);
        end
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        div_start = !div_stat.busy && !div_stat.done && (res_held_q == 1'b1);
        if (div_stat.done) begin
          last_weight_d = quot_sat;
          res_weight_d  = quot_sat;
          state_d       = ST_FINISH;
        end
        res_held_d = 1'b0;
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      sample_q <= s_axis_tdata_i[31] ? '0 : s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (load_out) begin
      m_weight_q <= res_weight_q;
      m_fill_q   <= fill_q;
      m_held_q   <= res_held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      fill_q        <= '0;
      window_q      <= WINDOW_W'(DefWin);
      sum_q         <= '0;
      last_weight_q <= '0;
      res_weight_q  <= '0;
      res_held_q    <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      fill_q        <= fill_d;
      window_q      <= window_d;
      sum_q         <= sum_d;
      last_weight_q <= last_weight_d;
      res_weight_q  <= res_weight_d;
      res_held_q    <= (state_q == ST_UPDATE) ? 1'b1 : res_held_d;
      m_valid_q     <= m_valid_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - WEIGHT_W - WINDOW_W)'(0), m_fill_q, m_weight_q};
  assign m_axis_tuser_o  = m_held_q;

`include "load_cell_moving_average_assert.svh"

  `LCMA_ASSERT_ALWAYS(a_fill_in_window, clk_i, rst_ni, fill_q <= window_q)
  `LCMA_ASSERT_ALWAYS(a_pos_in_window, clk_i, rst_ni, 8'(pos_q) < 8'(window_q))
  `LCMA_ASSERT_NEXT(a_cfg_clears, clk_i, rst_ni, cfg_fire, fill_q == '0 && pos_q == '0 && sum_q == '0)
  `LCMA_ASSERT_SAME(a_fresh_has_count, clk_i, rst_ni, m_valid_q && !m_held_q, m_fill_q != '0)
  `LCMA_ASSERT_NEXT(a_done_to_finish, clk_i, rst_ni, div_stat.done, state_q == ST_FINISH)

endmodule

FILE: bench/load_cell_moving_average_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// load_cell_moving_average_tb
// Streams weighing ticks into the moving-average block and checks every
// output beat against a cycle-free predictor of the ring, the running sum
// and the gram-to-kilogram division. A directed run at the reset window is
// followed by random runs at many window sizes, the out-of-range ones too.
// Both stream sides idle at random, with one run free of idling.
// ---------------------------------------------------------------------------
module load_cell_moving_average_tb;
  import lcma_pkg::*;

  localparam int unsigned MAX_WINDOW       = 16;
  localparam int unsigned SAMPLE_FRAC_BITS = 8;
  localparam int unsigned DEFAULT_WINDOW   = 8;
  localparam longint unsigned WEIGHT_MAX   = (64'd1 << WEIGHT_W) - 1;
  localparam int unsigned TICKS_PER_RUN    = 120;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned END_WAIT         = 60;

  typedef struct {
    bit                 ready;
    bit [IN_DATA_W-1:0] grams;
  } tick_t;

  typedef struct {
    bit [WEIGHT_W-1:0] kg;
    bit                held;
    bit [WINDOW_W-1:0] count;
  } weight_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [WINDOW_W-1:0]   cfg_data_i      = '0;

  tick_t   tick_q[$];
  weight_t weight_q[$];
  tick_t   tick_on_bus;
  bit      steady = 1'b0;
  int      error_count = 0;
  int unsigned cycle_count = 0;

  bit [SAMPLE_W-1:0] ring[MAX_WINDOW];
  int                ring_pos;
  int                ring_fill;
  int                window_len;
  longint unsigned   ring_sum;
  bit [WEIGHT_W-1:0] last_kg;

  load_cell_moving_average #(
    .MAX_WINDOW      (MAX_WINDOW),
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_window();
    foreach (ring[i]) ring[i] = '0;
    ring_pos  = 0;
    ring_fill = 0;
    ring_sum  = 0;
  endfunction

  task automatic predict_weight(input tick_t t);
    weight_t w;
    bit [SAMPLE_W-1:0] sample;
    int slot;
    longint unsigned scaled;
    longint unsigned divisor;
    longint unsigned quotient;
    if (t.ready) begin
      sample = t.grams[IN_DATA_W-1] ? '0 : t.grams[SAMPLE_W-1:0];
      slot = (ring_pos >= window_len) ? 0 : ring_pos;
      ring_sum = ring_sum - ring[slot] + sample;
      ring[slot] = sample;
      ring_pos = (slot + 1 >= window_len) ? 0 : slot + 1;
      if (ring_fill < window_len) ring_fill++;
      scaled = ring_sum << (KG_FRAC_BITS - SAMPLE_FRAC_BITS);
      divisor = longint'(GRAMS_PER_KG) * ring_fill;
      quotient = scaled / divisor;
      if (quotient > WEIGHT_MAX) quotient = WEIGHT_MAX;
      last_kg = quotient[WEIGHT_W-1:0];
    end
    w.kg    = last_kg;
    w.held  = !t.ready;
    w.count = ring_fill[WINDOW_W-1:0];
    weight_q.push_back(w);
  endtask

  task automatic check_weight(input bit [WEIGHT_W-1:0] kg, input bit held,
                              input bit [WINDOW_W-1:0] count);
    weight_t w;
    if (weight_q.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected beat: kg=%0d held=%0d count=%0d", kg, held, count);
    end else begin
      w = weight_q.pop_front();
      if (w.kg !== kg || w.held !== held || w.count !== count) begin
        error_count++;
        if (error_count <= 10)
          $display("mismatch: expected kg=%0d held=%0d count=%0d, got kg=%0d held=%0d count=%0d",
                   w.kg, w.held, w.count, kg, held, count);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) predict_weight(tick_on_bus);
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (rst_ni && tick_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        tick_on_bus = tick_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= tick_on_bus.grams;
        s_axis_tuser_i  <= tick_on_bus.ready;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      check_weight(m_axis_tdata_o[WEIGHT_W-1:0],
                   m_axis_tuser_o,
                   m_axis_tdata_o[WEIGHT_W+WINDOW_W-1:WEIGHT_W]);
    m_axis_tready_i <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit [IN_DATA_W-1:0] random_grams();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(200000);
      2: return {1'b0, 31'($urandom())};
      3: return {1'b1, 31'($urandom())};
      default: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic queue_tick(input bit ready, input bit [IN_DATA_W-1:0] grams);
    tick_t t;
    t.ready = ready;
    t.grams = grams;
    tick_q.push_back(t);
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || s_axis_tvalid_i || weight_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_window(input bit [WINDOW_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    window_len = (value == 0 || value > MAX_WINDOW) ? DEFAULT_WINDOW : value;
    clear_window();
  endtask

  initial begin
    int window_plan[12];
    window_plan = '{1, 16, 0, 31, 17, 5, 8, 12, 2, 16, 1, 3};
    clear_window();
    last_kg    = '0;
    window_len = DEFAULT_WINDOW;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_tick(1'b0, 32'h1234_5678);
    queue_tick(1'b1, 32'h0000_0000);
    queue_tick(1'b1, 32'h0000_0001);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h8000_0000);
    queue_tick(1'b1, 32'hFFFF_FFFF);
    queue_tick(1'b0, 32'hFFFF_FFFF);
    queue_tick(1'b1, 32'h00FA_0000);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b1, 32'h7FFF_FFFF);
    queue_tick(1'b0, 32'h0000_0000);
    queue_tick(1'b1, 32'h0000_03E8);
    queue_tick(1'b1, 32'hC000_0000);
    queue_tick(1'b1, 32'h4000_0000);
    drain();
    repeat (4) @(posedge clk_i);

    for (int run = 0; run < 14; run++) begin
      if (run < 12) write_window(window_plan[run]);
      else write_window($urandom_range(31));
      steady = (run == 4);
      queue_tick(1'b0, $urandom());
      for (int n = 0; n < TICKS_PER_RUN; n++)
        queue_tick($urandom_range(99) < 85, random_grams());
      drain();
      repeat (4) @(posedge clk_i);
    end

    steady = 1'b0;
    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
